// ===== rtl/bdsu_pkg.sv =====
package bdsu_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned MAX_BYTES_D = 4;
  // decimal_shift spans -16..15, so at most sixteen steps of times or divide by ten
  localparam int unsigned SHIFT_CELLS = 16;
  localparam int unsigned SHIFT_W     = 5;
  localparam int unsigned COUNT_W     = 3;
  localparam int unsigned DIGITS      = 8;
  localparam int unsigned DIG_IDX_W   = 4;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 5;

  localparam logic [CFG_IDX_W-1:0] REG_DECIMAL_SHIFT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYTE_COUNT    = 1'd1;

  // reciprocal of ten for an exact 32-bit quotient: q = (x * RECIP10) >> 35
  localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

  typedef struct packed {
    logic [WORD_W-1:0]           word;
    logic                        ok;
    logic [COUNT_W-1:0]          nbytes;
    logic signed [SHIFT_W-1:0]   steps;
    logic [WORD_W-1:0]           val;
    logic [DIG_IDX_W-1:0]        dig_idx;
    logic [DIGITS-1:0][3:0]      digits;
  } cell_t;

endpackage

// ===== rtl/bcd_decimal_shift_unit.sv =====
// Decimal shift of a packed BCD word. Each beat on the slave stream carries up to four
// BCD bytes; the low byte_count bytes are checked, decoded to binary, scaled by ten to
// the power decimal_shift (wrapping on multiply, truncating on divide) and re-encoded,
// while higher bytes pass through. A word with a non-decimal nibble returns unchanged
// with the tuser flag low. One word is taken every cycle while the output is not stalled.
// The pipeline is the decode stages, a row of sixteen shift cells and 2*MAX_BYTES digit
// cells, each one times-or-divide-by-ten step, and the output register. Every stage holds
// its beat under backpressure and refills as soon as it empties. Write decimal_shift and
// byte_count only while no beat is in flight.
module bcd_decimal_shift_unit #(
  parameter int unsigned MAX_BYTES = bdsu_pkg::MAX_BYTES_D
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [bdsu_pkg::WORD_W-1:0]       s_axis_tdata,   // [31:0] bcd_value
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [bdsu_pkg::WORD_W-1:0]       m_axis_tdata,   // [31:0] result_bcd
  output logic [0:0]                        m_axis_tuser,   // [0] input_valid
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bdsu_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bdsu_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import bdsu_pkg::*;

  localparam int unsigned N_DIGITS = 2 * MAX_BYTES;
  localparam int unsigned N_CELLS  = SHIFT_CELLS + N_DIGITS;

  logic signed [SHIFT_W-1:0] decimal_shift_q;
  logic [COUNT_W-1:0]        byte_count_q;

  logic  cv [N_CELLS+1];
  logic  cr [N_CELLS+1];
  cell_t cd [N_CELLS+1];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decimal_shift_q <= '0;
      byte_count_q    <= COUNT_W'(4);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_DECIMAL_SHIFT: decimal_shift_q <= cfg_data_i[SHIFT_W-1:0];
        REG_BYTE_COUNT:    byte_count_q    <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  bdsu_front #(
    .MAX_BYTES(MAX_BYTES)
  ) u_front (
    .clk_i,
    .rst_ni,
    .valid_i      (s_axis_tvalid),
    .ready_o      (s_axis_tready),
    .word_i       (s_axis_tdata),
    .shift_i      (decimal_shift_q),
    .byte_count_i (byte_count_q),
    .valid_o      (cv[0]),
    .ready_i      (cr[0]),
    .data_o       (cd[0])
  );

  for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
    bdsu_cell #(
      .NUM_DIGITS(N_DIGITS)
    ) u_cell (
      .clk_i,
      .rst_ni,
      .valid_i (cv[g]),
      .ready_o (cr[g]),
      .data_i  (cd[g]),
      .valid_o (cv[g+1]),
      .ready_i (cr[g+1]),
      .data_o  (cd[g+1])
    );
  end

  bdsu_back u_back (
    .clk_i,
    .rst_ni,
    .valid_i  (cv[N_CELLS]),
    .ready_o  (cr[N_CELLS]),
    .data_i   (cd[N_CELLS]),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (m_axis_tdata),
    .ok_o     (m_axis_tuser[0])
  );

  // decoded value of at most eight digits
  a_decode_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cv[0] && cd[0].ok) |-> (cd[0].val < 32'd100000000))
    else $error("decoded value out of range");

  // every beat leaving the row has finished its shift and all its digits
  a_row_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cv[N_CELLS] |-> (cd[N_CELLS].steps == 0 &&
                     cd[N_CELLS].dig_idx == DIG_IDX_W'(N_DIGITS)))
    else $error("beat left the cell row unfinished");

  a_digits_decimal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cv[N_CELLS] |-> (cd[N_CELLS].digits[0] <= 4'd9 && cd[N_CELLS].digits[1] <= 4'd9 &&
                     cd[N_CELLS].digits[2] <= 4'd9 && cd[N_CELLS].digits[3] <= 4'd9 &&
                     cd[N_CELLS].digits[4] <= 4'd9 && cd[N_CELLS].digits[5] <= 4'd9 &&
                     cd[N_CELLS].digits[6] <= 4'd9 && cd[N_CELLS].digits[7] <= 4'd9))
    else $error("digit cell produced a non-decimal nibble");

  // a stalled output must still let the row refill when the first cell is empty
  a_fill_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cv[1] |-> cr[0])
    else $error("first cell empty but not ready");

endmodule

// ===== rtl/bdsu_front.sv =====
module bdsu_front #(
  parameter int unsigned MAX_BYTES = bdsu_pkg::MAX_BYTES_D
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  logic [bdsu_pkg::WORD_W-1:0]           word_i,
  input  logic signed [bdsu_pkg::SHIFT_W-1:0]   shift_i,
  input  logic [bdsu_pkg::COUNT_W-1:0]          byte_count_i,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output bdsu_pkg::cell_t                       data_o
);
  import bdsu_pkg::*;

  // first stage: check nibbles, decode each byte to 0..99
  logic                      v1_q, v1_d;
  logic [WORD_W-1:0]         word_q, word_d;
  logic                      ok_q, ok_d;
  logic [COUNT_W-1:0]        n_q, n_d;
  logic signed [SHIFT_W-1:0] shift_q, shift_d;
  logic [3:0][6:0]           bval_q, bval_d;
  logic                      rdy1;

  // second stage: weighted sum of the byte values
  logic                      v2_q, v2_d;
  cell_t                     c2_q, c2_d;
  logic                      rdy2;

  assign rdy2    = !v2_q || ready_i;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  always_comb begin
    logic [3:0] hi;
    logic [3:0] lo;
    logic       used;
    n_d     = (byte_count_i > COUNT_W'(MAX_BYTES)) ? COUNT_W'(MAX_BYTES) : byte_count_i;
    ok_d    = 1'b1;
    word_d  = word_i;
    shift_d = shift_i;
    v1_d    = valid_i;
    for (int i = 0; i < 4; i++) begin
      hi   = word_i[8*i+4 +: 4];
      lo   = word_i[8*i +: 4];
      used = (COUNT_W'(i) < n_d);
      if (used && (hi > 4'd9 || lo > 4'd9)) ok_d = 1'b0;
      bval_d[i] = used ? (7'({hi, 3'b000}) + 7'({hi, 1'b0}) + 7'(lo)) : 7'd0;
    end
  end

  always_comb begin
    c2_d         = c2_q;
    v2_d         = v1_q;
    c2_d.word    = word_q;
    c2_d.ok      = ok_q;
    c2_d.nbytes  = n_q;
    c2_d.steps   = shift_q;
    c2_d.val     = 32'(bval_q[0]) + 32'(bval_q[1]) * 32'd100
                 + 32'(bval_q[2]) * 32'd10000 + 32'(bval_q[3]) * 32'd1000000;
    c2_d.dig_idx = '0;
    c2_d.digits  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= v1_d;
      if (rdy2) v2_q <= v2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      word_q  <= word_d;
      ok_q    <= ok_d;
      n_q     <= n_d;
      shift_q <= shift_d;
      bval_q  <= bval_d;
    end
    if (rdy2) c2_q <= c2_d;
  end

  assign valid_o = v2_q;
  assign data_o  = c2_q;

endmodule

// ===== rtl/bdsu_cell.sv =====
module bdsu_cell #(
  parameter int unsigned NUM_DIGITS = 2 * bdsu_pkg::MAX_BYTES_D
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  bdsu_pkg::cell_t data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output bdsu_pkg::cell_t data_o
);
  import bdsu_pkg::*;

  logic        v_q;
  cell_t       c_q, c_d;
  logic [63:0] prod;
  logic [31:0] quot;
  logic [31:0] rem_w;
  logic [31:0] mul10;
  logic        load;

  assign load    = !v_q || ready_i;
  assign ready_o = load;

  assign prod  = 64'(data_i.val) * 64'(RECIP10);
  assign quot  = 32'(prod[63:35]);
  assign rem_w = data_i.val - ({quot[28:0], 3'b000} + {quot[30:0], 1'b0});
  assign mul10 = {data_i.val[28:0], 3'b000} + {data_i.val[30:0], 1'b0};

  // shift first, one power of ten a cell; then peel off one digit a cell
  always_comb begin
    c_d = data_i;
    if (data_i.steps > 0) begin
      c_d.val   = mul10;
      c_d.steps = data_i.steps - SHIFT_W'(1);
    end else if (data_i.steps < 0) begin
      c_d.val   = quot;
      c_d.steps = data_i.steps + SHIFT_W'(1);
    end else if (data_i.dig_idx < DIG_IDX_W'(NUM_DIGITS)) begin
      c_d.val                        = quot;
      c_d.digits[data_i.dig_idx[2:0]] = rem_w[3:0];
      c_d.dig_idx                    = data_i.dig_idx + DIG_IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (load) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) c_q <= c_d;
  end

  assign valid_o = v_q;
  assign data_o  = c_q;

endmodule

// ===== rtl/bdsu_back.sv =====
module bdsu_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  bdsu_pkg::cell_t               data_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [bdsu_pkg::WORD_W-1:0]   result_o,
  output logic                          ok_o
);
  import bdsu_pkg::*;

  logic              v_q;
  logic [WORD_W-1:0] res_q, res_d;
  logic              ok_q;
  logic              load;

  assign load    = !v_q || ready_i;
  assign ready_o = load;

  // for a decimal word, replace the used bytes with the new digit pairs, keep the rest
  always_comb begin
    res_d = data_i.word;
    if (data_i.ok) begin
      for (int i = 0; i < 4; i++) begin
        if (COUNT_W'(i) < data_i.nbytes) begin
          res_d[8*i +: 8] = {data_i.digits[2*i+1], data_i.digits[2*i]};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (load) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
      ok_q  <= data_i.ok;
    end
  end

  assign valid_o  = v_q;
  assign result_o = res_q;
  assign ok_o     = ok_q;

endmodule
